[design/mcms_pkg.sv]
// Shared constants, types and helpers for the masked cost matrix minimum search core.
package mcms_pkg;

  localparam int MAX_SIZE   = 64;
  localparam int IDX_W      = $clog2(MAX_SIZE);
  localparam int CNT_W      = $clog2(MAX_SIZE + 1);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int MEM_DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int VAL_W      = 32;
  localparam int OP_W       = 3;
  localparam int SIZE_W     = 7;
  localparam int DATA_W     = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [VAL_W-1:0] VALUE_MAX       = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic             REG_ACTIVE_SIZE = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE     = 3'd0,
    OP_READ      = 3'd1,
    OP_ERASE_ROW = 3'd2,
    OP_ERASE_COL = 3'd3,
    OP_ROW_MIN   = 3'd4,
    OP_COL_MIN   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_WRITE,
    CMD_READ,
    CMD_ERASE_ROW,
    CMD_ERASE_COL,
    CMD_ROW_MIN,
    CMD_COL_MIN,
    CMD_NO_HIT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [VAL_W-1:0]  value;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_SCAN
  } bk_state_t;

  // active_size clamped to 1..MAX_SIZE
  function automatic logic [CNT_W-1:0] eff_size(input logic [SIZE_W-1:0] sz);
    logic [CNT_W-1:0] n;
    if (sz == '0) begin
      n = CNT_W'(1);
    end else if (sz > SIZE_W'(MAX_SIZE)) begin
      n = CNT_W'(MAX_SIZE);
    end else begin
      n = sz[CNT_W-1:0];
    end
    return n;
  endfunction

endpackage

[design/mcms_front.sv]
// Front end: accepts requests, range-checks them and turns them into commands.
module mcms_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [mcms_pkg::OP_W-1:0]     in_operation,
  input  logic [mcms_pkg::IDX_W-1:0]    in_row_index,
  input  logic [mcms_pkg::IDX_W-1:0]    in_col_index,
  input  logic signed [mcms_pkg::VAL_W-1:0] in_entry_value,
  input  logic [mcms_pkg::SIZE_W-1:0]   active_size,
  input  logic                          hold,
  output logic                          cmd_valid,
  output mcms_pkg::cmd_t                cmd,
  input  logic                          cmd_ready
);
  import mcms_pkg::*;

  logic             fr_valid_r, fr_valid_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [CNT_W-1:0] n;
  logic             row_ok, col_ok, accept;

  assign n      = eff_size(active_size);
  assign row_ok = CNT_W'(in_row_index) < n;
  assign col_ok = CNT_W'(in_col_index) < n;
  assign full   = hold || (fr_valid_r && !cmd_ready);
  assign accept = push && !full;

  always_comb begin
    cmd_nxt       = cmd_r;
    fr_valid_nxt  = fr_valid_r && !cmd_ready;
    if (accept) begin
      fr_valid_nxt  = 1'b1;
      cmd_nxt.row   = in_row_index;
      cmd_nxt.col   = in_col_index;
      cmd_nxt.value = in_entry_value;
      case (op_t'(in_operation))
        OP_WRITE:     cmd_nxt.kind = (row_ok && col_ok) ? CMD_WRITE : CMD_NOP;
        OP_READ:      cmd_nxt.kind = (row_ok && col_ok) ? CMD_READ : CMD_NOP;
        OP_ERASE_ROW: cmd_nxt.kind = row_ok ? CMD_ERASE_ROW : CMD_NOP;
        OP_ERASE_COL: cmd_nxt.kind = col_ok ? CMD_ERASE_COL : CMD_NOP;
        OP_ROW_MIN:   cmd_nxt.kind = row_ok ? CMD_ROW_MIN : CMD_NO_HIT;
        OP_COL_MIN:   cmd_nxt.kind = col_ok ? CMD_COL_MIN : CMD_NO_HIT;
        default:      cmd_nxt.kind = CMD_NOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  assign cmd_valid = fr_valid_r;
  assign cmd       = cmd_r;

endmodule

[design/mcms_cmd_fifo.sv]
// Short command queue between front end and back end.
module mcms_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  mcms_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_pop,
  output mcms_pkg::cmd_t rd_data
);
  import mcms_pkg::*;

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               wr, rd;

  assign wr_ready = cnt_r != Q_CNT_W'(Q_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = slot_r[rd_ptr_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(wr) - Q_CNT_W'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[design/mcms_back.sv]
// Back end: cost memory, line masks, entry access and line minimum scans.
module mcms_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [mcms_pkg::SIZE_W-1:0]       active_size,
  input  logic                              cmd_valid,
  input  mcms_pkg::cmd_t                    cmd_in,
  output logic                              cmd_pop,
  output logic                              clearing,
  output logic                              res_valid,
  input  logic                              res_pop,
  output logic signed [mcms_pkg::VAL_W-1:0] res_value,
  output logic [mcms_pkg::IDX_W-1:0]        res_index,
  output logic                              res_found
);
  import mcms_pkg::*;

  logic signed [VAL_W-1:0] mem [MEM_DEPTH];

  bk_state_t               state_r, state_nxt;
  logic [ADDR_W-1:0]       clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]        k_r, k_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  logic [MAX_SIZE-1:0]     row_active_r, row_active_nxt;
  logic [MAX_SIZE-1:0]     col_active_r, col_active_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  logic                    cmp_act_r, cmp_act_nxt;
  logic [IDX_W-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic signed [VAL_W-1:0] rd_data_r;
  logic signed [VAL_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]        best_idx_r, best_idx_nxt;
  logic                    seen_r, seen_nxt;
  logic                    res_valid_r, res_valid_nxt;
  logic signed [VAL_W-1:0] res_value_r, res_value_nxt;
  logic [IDX_W-1:0]        res_index_r, res_index_nxt;
  logic                    res_found_r, res_found_nxt;

  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
  logic signed [VAL_W-1:0] mem_wdata;

  logic [CNT_W-1:0]        n;
  logic                    start, issue, last, hit, by_row;
  logic signed [VAL_W-1:0] best_upd;
  logic [IDX_W-1:0]        idx_upd;
  logic                    seen_upd;
  logic [IDX_W-1:0]        k_idx;

  assign n      = eff_size(active_size);
  assign start  = (state_r == BK_IDLE) && cmd_valid && !res_valid_r;
  assign issue  = (state_r == BK_SCAN) && (k_r < n);
  assign last   = (state_r == BK_SCAN) && (k_r == n);
  assign by_row = cmd_r.kind == CMD_ROW_MIN;
  assign k_idx  = k_r[IDX_W-1:0];

  assign hit      = cmp_vld_r && cmp_act_r && (!seen_r || (rd_data_r < best_r));
  assign best_upd = hit ? rd_data_r : best_r;
  assign idx_upd  = hit ? cmp_idx_r : best_idx_r;
  assign seen_upd = seen_r || hit;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (clr_addr_r == ADDR_W'(MEM_DEPTH - 1)) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (start) begin
          if (cmd_in.kind == CMD_READ) begin
            state_nxt = BK_READ;
          end else if (cmd_in.kind == CMD_ROW_MIN || cmd_in.kind == CMD_COL_MIN) begin
            state_nxt = BK_SCAN;
          end
        end
      end
      BK_READ: state_nxt = BK_IDLE;
      BK_SCAN: begin
        if (last) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop        = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = clr_addr_r;
    mem_wdata      = '0;
    mem_raddr      = {cmd_in.row, cmd_in.col};
    clr_addr_nxt   = clr_addr_r;
    k_nxt          = k_r;
    cmd_nxt        = cmd_r;
    row_active_nxt = row_active_r;
    col_active_nxt = col_active_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    seen_nxt       = seen_r;
    cmp_vld_nxt    = issue;
    cmp_idx_nxt    = k_idx;
    cmp_act_nxt    = by_row ? col_active_r[k_idx] : row_active_r[k_idx];
    res_valid_nxt  = res_valid_r && !res_pop;
    res_value_nxt  = res_value_r;
    res_index_nxt  = res_index_r;
    res_found_nxt  = res_found_r;
    case (state_r)
      BK_CLEAR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      BK_IDLE: begin
        if (start) begin
          cmd_pop       = 1'b1;
          cmd_nxt       = cmd_in;
          res_valid_nxt = 1'b1;
          res_value_nxt = '0;
          res_index_nxt = '0;
          res_found_nxt = 1'b0;
          case (cmd_in.kind)
            CMD_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = {cmd_in.row, cmd_in.col};
              mem_wdata = cmd_in.value;
            end
            CMD_ERASE_ROW: row_active_nxt[cmd_in.row] = 1'b0;
            CMD_ERASE_COL: col_active_nxt[cmd_in.col] = 1'b0;
            CMD_NO_HIT:    res_value_nxt = VALUE_MAX;
            CMD_READ:      res_valid_nxt = 1'b0;
            CMD_ROW_MIN, CMD_COL_MIN: begin
              res_valid_nxt = 1'b0;
              k_nxt         = '0;
              best_nxt      = VALUE_MAX;
              best_idx_nxt  = '0;
              seen_nxt      = 1'b0;
            end
            default: res_value_nxt = '0;
          endcase
        end
      end
      BK_READ: begin
        res_valid_nxt = 1'b1;
        res_value_nxt = rd_data_r;
        res_index_nxt = '0;
        res_found_nxt = 1'b0;
      end
      BK_SCAN: begin
        best_nxt     = best_upd;
        best_idx_nxt = idx_upd;
        seen_nxt     = seen_upd;
        if (issue) begin
          mem_raddr = by_row ? {cmd_r.row, k_idx} : {k_idx, cmd_r.col};
          k_nxt     = k_r + 1'b1;
        end
        if (last) begin
          res_valid_nxt = 1'b1;
          res_value_nxt = best_upd;
          res_index_nxt = idx_upd;
          res_found_nxt = seen_upd;
        end
      end
      default: cmd_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_CLEAR;
      clr_addr_r   <= '0;
      row_active_r <= '1;
      col_active_r <= '1;
      cmp_vld_r    <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      row_active_r <= row_active_nxt;
      col_active_r <= col_active_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    cmd_r       <= cmd_nxt;
    cmp_act_r   <= cmp_act_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    best_r      <= best_nxt;
    best_idx_r  <= best_idx_nxt;
    seen_r      <= seen_nxt;
    res_value_r <= res_value_nxt;
    res_index_r <= res_index_nxt;
    res_found_r <= res_found_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  assign clearing  = state_r == BK_CLEAR;
  assign res_valid = res_valid_r;
  assign res_value = res_value_r;
  assign res_index = res_index_r;
  assign res_found = res_found_r;

endmodule

[design/masked_cost_matrix_min_search_core.sv]
// Top level of the masked cost matrix minimum search core.
// A 64 x 64 matrix of signed Q16.16 costs with one active bit per row and per
// column. Requests write or read one entry, erase a row or column, or search a
// row (over active columns) or a column (over active rows) for its minimum,
// lowest index winning ties; every request gives one result. After reset the
// cost memory is cleared one entry per cycle, and full stays high until it
// is done; configuration writes are taken during that time. A minimum search
// reads n entries of its line, n being active_size clamped to 1..64, one
// entry per cycle through the single memory read port. A result must be
// popped before the back end starts the next request; up to three further
// requests are buffered in the front end register and the command queue
// meanwhile.
module masked_cost_matrix_min_search_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  output logic                                  full,
  input  logic [mcms_pkg::OP_W-1:0]             in_operation,
  input  logic [mcms_pkg::IDX_W-1:0]            in_row_index,
  input  logic [mcms_pkg::IDX_W-1:0]            in_col_index,
  input  logic signed [mcms_pkg::VAL_W-1:0]     in_entry_value,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [mcms_pkg::VAL_W-1:0]     out_result_value,
  output logic [mcms_pkg::IDX_W-1:0]            out_result_index,
  output logic                                  out_found,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mcms_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [mcms_pkg::DATA_W-1:0]           pwdata,
  output logic [mcms_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);
  import mcms_pkg::*;

  logic [SIZE_W-1:0] active_size_r, active_size_nxt;
  logic              cfg_sel;
  logic              clearing;
  logic              fr_valid, fr_ready;
  cmd_t              fr_cmd;
  logic              q_valid, q_pop;
  cmd_t              q_cmd;
  logic              res_valid;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[CFG_ADDR_W-1] == REG_ACTIVE_SIZE;
  assign prdata  = cfg_sel ? DATA_W'(active_size_r) : '0;

  always_comb begin
    active_size_nxt = active_size_r;
    if (psel && penable && pwrite && pready && cfg_sel) begin
      active_size_nxt = pwdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_size_r <= SIZE_W'(MAX_SIZE);
    end else begin
      active_size_r <= active_size_nxt;
    end
  end

  mcms_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_operation   (in_operation),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .in_entry_value (in_entry_value),
    .active_size    (active_size_r),
    .hold           (clearing),
    .cmd_valid      (fr_valid),
    .cmd            (fr_cmd),
    .cmd_ready      (fr_ready)
  );

  mcms_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  (fr_cmd),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_cmd)
  );

  mcms_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .active_size (active_size_r),
    .cmd_valid   (q_valid),
    .cmd_in      (q_cmd),
    .cmd_pop     (q_pop),
    .clearing    (clearing),
    .res_valid   (res_valid),
    .res_pop     (pop),
    .res_value   (out_result_value),
    .res_index   (out_result_index),
    .res_found   (out_found)
  );

  assign empty = !res_valid;

endmodule

[design/mcms_checker.sv]
// Port-level checks for the masked cost matrix minimum search core, with bind.
module mcms_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              full,
  input logic                              empty,
  input logic                              pop,
  input logic signed [mcms_pkg::VAL_W-1:0] out_result_value,
  input logic [mcms_pkg::IDX_W-1:0]        out_result_index,
  input logic                              out_found
);
  import mcms_pkg::*;

  // no result survives reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result present after reset");

  // memory clear pass blocks requests right after reset
  a_reset_full: assert property (@(posedge clk) !rst_n |=> full)
    else $error("request port open during memory clear");

  // a waiting result holds until popped
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_result_value)
      && $stable(out_result_index) && $stable(out_found)))
    else $error("waiting result changed");

  // index is only reported for a successful search
  a_idx_found: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_found) |-> (out_result_index == '0))
    else $error("index without found");

endmodule

bind masked_cost_matrix_min_search_core mcms_checker u_mcms_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .out_result_value (out_result_value),
  .out_result_index (out_result_index),
  .out_found        (out_found)
);
